@@ rtl/core/node_drag_motion_step_unit_defines.svh @@
// assertion macros for the node drag motion step unit
`ifndef NODE_DRAG_MOTION_STEP_UNIT_DEFINES_SVH
`define NODE_DRAG_MOTION_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define NDM_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ndm assertion failed");

// next-cycle implication
`define NDM_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ndm assertion failed");

`endif

@@ rtl/core/ndm_pkg.sv @@
// shared types, codes, constants and helpers of the node drag motion unit
package ndm_pkg;

  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
  localparam logic [63:0] DAMP_LIMIT = 64'd65536000000000;

  // floor(2^61 / 1e9): x / 1e9 is estimated as ((x >> 29) * RECIP_1E9) >> 32
  localparam logic [31:0] RECIP_1E9 = 32'd2305843009;

  localparam logic [30:0] HIT_RADIUS_RST   = 31'd1310720;
  localparam logic [15:0] DAMPING_RST      = 16'd58982;
  localparam logic [30:0] FRICTION_RST     = 31'd3276800;

  typedef enum logic [2:0] {
    CMD_FORCE   = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_PRESS   = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_MOVE    = 3'd4,
    CMD_SETPOS  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    REG_HIT_RADIUS = 2'd0,
    REG_DAMPING    = 2'd1,
    REG_FRICTION   = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_MUL,
    S_RECIP,
    S_BACK,
    S_FIX,
    S_DSTART,
    S_DIV,
    S_SQSTART,
    S_SQRT,
    S_WB,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    J_FX, J_FY, J_DAMP, J_DX, J_DY, J_SQX, J_SQY, J_STEP,
    J_FRX, J_FRY, J_PX, J_PY, J_HX, J_HY, J_HR
  } job_t;

  // handshake of an iterative unit
  typedef struct packed {
    logic start;
    logic busy;
  } unit_ctl_t;

  function automatic logic [32:0] mag32(input logic [31:0] v);
    return v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
  endfunction

  function automatic logic [31:0] apply_sign(input logic neg, input logic [32:0] m);
    logic [32:0] n;
    n = 33'd0 - m;
    return neg ? n[31:0] : m[31:0];
  endfunction

  function automatic logic [31:0] sat35(input logic [34:0] s);
    if (s[34:31] == 4'b0000 || s[34:31] == 4'b1111) return s[31:0];
    return s[34] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  // a plus or minus m, saturated to 32 bits signed
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic neg,
                                          input logic [32:0] m);
    logic [34:0] sm;
    sm = neg ? (35'd0 - {2'b00, m}) : {2'b00, m};
    return sat35({{3{a[31]}}, a} + sm);
  endfunction

endpackage

@@ rtl/core/ndm_if.sv @@
// valid/ready channels for commands and results
interface ndm_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] vec_x;
  logic [31:0] vec_y;
  logic [29:0] dt_ns;
  modport source (output valid, cmd, vec_x, vec_y, dt_ns, input ready);
  modport sink (input valid, cmd, vec_x, vec_y, dt_ns, output ready);
endinterface

interface ndm_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic        dragged;
  modport source (output valid, pos_x, pos_y, dragged, input ready);
  modport sink (input valid, pos_x, pos_y, dragged, output ready);
endinterface

@@ rtl/core/node_drag_motion_step_unit.sv @@
// top level: command sequencer, shared multiplier, state and result register
//
//  channel   dir  handshake      payload
//  cmd_in    in   valid/ready    cmd, vec_x, vec_y, dt_ns
//  result    out  valid/ready    pos_x, pos_y, dragged
//  cfg       in   cfg_we only    cfg_index, cfg_data
//
// force, release, move, set position, missed press, spare codes: dispatch, then done
// press inside the radius box: three passes through the multiplier
// free tick: a square root and, unless friction stops the point, two friction
// divides; each /1e9 is a reciprocal multiply plus up to three fixups
// cmd_in.ready only while idle; a done command waits for the one output register
// rst (synchronous) clears the motion state and reloads register defaults
module node_drag_motion_step_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [30:0]     cfg_data,
  ndm_cmd_if.sink         cmd_in,
  ndm_res_if.source       result
);
  import ndm_pkg::*;
  `include "node_drag_motion_step_unit_defines.svh"

  state_t state, state_next;
  job_t   job;

  logic [30:0] hit_radius;
  logic [15:0] damping_factor;
  logic [30:0] friction_rate;

  logic [31:0] px, py, vx, vy, fx, fy, tx, ty;
  logic        held;

  logic [2:0]  cmd_l;
  logic [31:0] vec_x_l, vec_y_l;
  logic [29:0] dt_l;

  logic [63:0] prod, acc;
  logic [32:0] f;
  logic [31:0] step, mag;

  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_full;
  logic [63:0] div_dividend;
  logic [32:0] div_divisor;
  logic [63:0] div_q;
  logic [63:0] quo;
  logic [32:0] qc, rc;
  logic [63:0] back_diff;
  logic [31:0] root;
  unit_ctl_t   div_ctl, sq_ctl;
  logic        div_busy, sq_busy;

  logic [32:0] ax, ay, dx, dy, ddx, ddy;
  logic        div_job, const_job, done_ok;

  assign ax  = mag32(vx);
  assign ay  = mag32(vy);
  assign ddx = {vec_x_l[31], vec_x_l} - {px[31], px};
  assign ddy = {vec_y_l[31], vec_y_l} - {py[31], py};
  assign dx  = ddx[32] ? (33'd0 - ddx) : ddx;
  assign dy  = ddy[32] ? (33'd0 - ddy) : ddy;

  assign div_job   = (job == J_FRX || job == J_FRY);
  assign const_job = (job == J_FX || job == J_FY || job == J_DAMP || job == J_STEP ||
                      job == J_PX || job == J_PY);
  assign done_ok = !result.valid || result.ready;

  always_comb begin
    if (state == S_RECIP) begin
      mul_a = div_dividend[61:29];
      mul_b = {1'b0, RECIP_1E9};
    end else if (state == S_BACK) begin
      mul_a = qc;
      mul_b = NS_PER_SEC[32:0];
    end else begin
      unique case (job)
        J_FX:    begin mul_a = mag32(fx); mul_b = {3'b000, dt_l}; end
        J_FY:    begin mul_a = mag32(fy); mul_b = {3'b000, dt_l}; end
        J_DAMP:  begin mul_a = {17'd0, damping_factor}; mul_b = {3'b000, dt_l}; end
        J_DX:    begin mul_a = ax; mul_b = f; end
        J_DY:    begin mul_a = ay; mul_b = f; end
        J_SQX:   begin mul_a = ax; mul_b = ax; end
        J_SQY:   begin mul_a = ay; mul_b = ay; end
        J_STEP:  begin mul_a = {2'b00, friction_rate}; mul_b = {3'b000, dt_l}; end
        J_FRX:   begin mul_a = ax; mul_b = {1'b0, step}; end
        J_FRY:   begin mul_a = ay; mul_b = {1'b0, step}; end
        J_PX:    begin mul_a = ax; mul_b = {3'b000, dt_l}; end
        J_PY:    begin mul_a = ay; mul_b = {3'b000, dt_l}; end
        J_HX:    begin mul_a = dx; mul_b = dx; end
        J_HY:    begin mul_a = dy; mul_b = dy; end
        default: begin mul_a = {2'b00, hit_radius}; mul_b = {2'b00, hit_radius}; end
      endcase
    end
  end

  // every dividend over 1e9 stays below 2^62
  assign mul_full     = mul_a * mul_b;
  assign div_dividend = (job == J_DAMP) ? {prod[47:0], 16'd0} : prod;
  assign div_divisor  = {1'b0, mag};
  assign back_diff    = div_dividend - mul_full[63:0];
  assign quo          = div_job ? div_q : {31'd0, qc};

  ndm_divider u_div (
    .clk(clk), .rst(rst), .ctl_in(div_ctl), .busy(div_busy),
    .dividend(prod), .divisor(div_divisor), .quotient(div_q)
  );

  ndm_isqrt u_sqrt (
    .clk(clk), .rst(rst), .ctl_in(sq_ctl), .busy(sq_busy),
    .radicand(acc + prod), .root(root)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (cmd_in.valid) state_next = S_DISP;
      S_DISP: begin
        if (cmd_l == CMD_TICK && dt_l != 30'd0 && !held) state_next = S_MUL;
        else if (cmd_l == CMD_PRESS && dx <= {2'b00, hit_radius} &&
                 dy <= {2'b00, hit_radius}) state_next = S_MUL;
        else state_next = S_DONE;
      end
      S_MUL: begin
        if (const_job) state_next = S_RECIP;
        else if (div_job) state_next = S_DSTART;
        else if (job == J_SQY) state_next = S_SQSTART;
        else state_next = S_WB;
      end
      S_RECIP:   state_next = S_BACK;
      S_BACK:    state_next = S_FIX;
      S_FIX:     if (rc < NS_PER_SEC[32:0]) state_next = S_WB;
      S_DSTART:  state_next = S_DIV;
      S_DIV:     if (!div_busy) state_next = S_WB;
      S_SQSTART: state_next = S_SQRT;
      S_SQRT:    if (!sq_busy) state_next = S_WB;
      S_WB: begin
        if (job == J_PY || job == J_HR) state_next = S_DONE;
        else state_next = S_MUL;
      end
      S_DONE:    if (done_ok) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // handshake and unit strobes
  always_comb begin
    cmd_in.ready  = (state == S_IDLE);
    div_ctl.start = (state == S_DSTART);
    div_ctl.busy  = div_busy;
    sq_ctl.start  = (state == S_SQSTART);
    sq_ctl.busy   = sq_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_radius     <= HIT_RADIUS_RST;
      damping_factor <= DAMPING_RST;
      friction_rate  <= FRICTION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIT_RADIUS: hit_radius     <= cfg_data;
        REG_DAMPING:    damping_factor <= cfg_data[15:0];
        REG_FRICTION:   friction_rate  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0; py <= '0; vx <= '0; vy <= '0;
      fx <= '0; fy <= '0; tx <= '0; ty <= '0;
      held <= 1'b0;
      job  <= J_FX;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && !(state == S_DONE && done_ok))
        result.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_in.valid) begin
            cmd_l   <= cmd_in.cmd;
            vec_x_l <= cmd_in.vec_x;
            vec_y_l <= cmd_in.vec_y;
            dt_l    <= cmd_in.dt_ns;
          end
        end
        S_DISP: begin
          unique case (cmd_l)
            CMD_FORCE: begin
              fx <= sat35({{3{fx[31]}}, fx} + {{3{vec_x_l[31]}}, vec_x_l});
              fy <= sat35({{3{fy[31]}}, fy} + {{3{vec_y_l[31]}}, vec_y_l});
            end
            CMD_TICK: begin
              job <= J_FX;
              if (dt_l != 30'd0 && held) begin
                px <= tx; py <= ty; fx <= '0; fy <= '0;
              end
            end
            CMD_PRESS:   job <= J_HX;
            CMD_RELEASE: held <= 1'b0;
            CMD_MOVE:    if (held) begin tx <= vec_x_l; ty <= vec_y_l; end
            CMD_SETPOS:  begin px <= vec_x_l; py <= vec_y_l; end
            default: ;
          endcase
        end
        S_MUL: prod <= mul_full[63:0];
        // quotient estimate is low by at most three
        S_RECIP: qc <= mul_full[64:32];
        S_BACK:  rc <= back_diff[32:0];
        S_FIX: begin
          if (rc >= NS_PER_SEC[32:0]) begin
            rc <= rc - NS_PER_SEC[32:0];
            qc <= qc + 33'd1;
          end
        end
        S_WB: begin
          unique case (job)
            J_FX: begin vx <= sat_add(vx, fx[31], quo[32:0]); job <= J_FY; end
            J_FY: begin vy <= sat_add(vy, fy[31], quo[32:0]); job <= J_DAMP; end
            J_DAMP: begin
              // damping above one second's worth stops the point
              if (prod > DAMP_LIMIT) begin
                vx <= '0; vy <= '0; job <= J_SQX;
              end else begin
                f <= quo[32:0]; job <= J_DX;
              end
            end
            J_DX: begin vx <= apply_sign(vx[31], ax - {1'b0, prod[63:32]}); job <= J_DY; end
            J_DY: begin vy <= apply_sign(vy[31], ay - {1'b0, prod[63:32]}); job <= J_SQX; end
            J_SQX: begin acc <= prod; job <= J_SQY; end
            J_SQY: begin acc <= '0; mag <= root; job <= J_STEP; end
            J_STEP: begin
              step <= quo[31:0];
              if ({32'd0, mag} <= quo) begin
                vx <= '0; vy <= '0; job <= J_PX;
              end else job <= J_FRX;
            end
            J_FRX: begin vx <= apply_sign(vx[31], ax - quo[32:0]); job <= J_FRY; end
            J_FRY: begin vy <= apply_sign(vy[31], ay - quo[32:0]); job <= J_PX; end
            J_PX: begin px <= sat_add(px, vx[31], quo[32:0]); job <= J_PY; end
            J_PY: begin
              py <= sat_add(py, vy[31], quo[32:0]);
              fx <= '0; fy <= '0;
            end
            J_HX: begin acc <= prod; job <= J_HY; end
            J_HY: begin acc <= acc + prod; job <= J_HR; end
            default: begin
              if (acc <= prod) begin
                held <= 1'b1; tx <= vec_x_l; ty <= vec_y_l;
              end
              acc <= '0;
            end
          endcase
        end
        S_DONE: begin
          if (done_ok) begin
            result.valid   <= 1'b1;
            result.pos_x   <= px;
            result.pos_y   <= py;
            result.dragged <= held;
          end
        end
        default: ;
      endcase
      if (state == S_IDLE && cmd_in.valid) acc <= '0;
    end
  end

  `NDM_ASSERT_NEXT(a_accept_dispatch, clk, rst, cmd_in.valid && cmd_in.ready, state == S_DISP)
  `NDM_ASSERT_NEXT(a_div_runs, clk, rst, state == S_DSTART, div_busy)
  `NDM_ASSERT_NEXT(a_release_drops, clk, rst, state == S_DISP && cmd_l == CMD_RELEASE, !held)
  `NDM_ASSERT_NOW(a_busy_not_ready, clk, rst, div_busy || sq_busy, !cmd_in.ready)

endmodule

@@ rtl/core/ndm_divider.sv @@
// restoring divider, 64-bit dividend by 33-bit divisor, one quotient bit a cycle
module ndm_divider (
  input  logic              clk,
  input  logic              rst,
  input  ndm_pkg::unit_ctl_t ctl_in,
  output logic              busy,
  input  logic [63:0]       dividend,
  input  logic [32:0]       divisor,
  output logic [63:0]       quotient
);
  import ndm_pkg::*;

  logic [32:0] rem;
  logic [32:0] dvs;
  logic [63:0] dq;
  logic [6:0]  cnt;
  logic [33:0] r2;
  logic        take;

  assign r2       = {rem, dq[63]};
  assign take     = r2 >= {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 7'd0;
    end else if (ctl_in.start) begin
      busy <= 1'b1;
      cnt  <= 7'd64;
      rem  <= 33'd0;
      dvs  <= divisor;
      dq   <= dividend;
    end else if (busy) begin
      rem  <= take ? 33'(r2 - {1'b0, dvs}) : r2[32:0];
      dq   <= {dq[62:0], take};
      cnt  <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
endmodule

@@ rtl/core/ndm_isqrt.sv @@
// integer square root of a 64-bit word, two radicand bits a cycle
module ndm_isqrt (
  input  logic              clk,
  input  logic              rst,
  input  ndm_pkg::unit_ctl_t ctl_in,
  output logic              busy,
  input  logic [63:0]       radicand,
  output logic [31:0]       root
);
  import ndm_pkg::*;

  logic [34:0] rem;
  logic [63:0] x;
  logic [5:0]  cnt;
  logic [35:0] r2;
  logic [35:0] trial;
  logic        take;

  assign r2    = {rem[33:0], x[63:62]};
  assign trial = {2'b00, root, 2'b01};
  assign take  = r2 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
    end else if (ctl_in.start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
      rem  <= 35'd0;
      root <= 32'd0;
      x    <= radicand;
    end else if (busy) begin
      rem  <= take ? 35'(r2 - trial) : r2[34:0];
      root <= {root[30:0], take};
      x    <= {x[61:0], 2'b00};
      cnt  <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end
endmodule
